// File: hw/rtl/circle_overlap_test_top_assert.svh
// ----------------------------------------------------------------------------
// circle_overlap_test_top_assert.svh
// Assertion macros for the circle overlap test.
// ----------------------------------------------------------------------------
`ifndef CIRCLE_OVERLAP_TEST_TOP_ASSERT_SVH
`define CIRCLE_OVERLAP_TEST_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define COT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define COT_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define COT_ASSERT(lbl, prop, msg)
`define COT_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// File: hw/rtl/cot_pkg.sv
// ----------------------------------------------------------------------------
// cot_pkg
// Shared constants and types of the circle overlap test.
// ----------------------------------------------------------------------------
package cot_pkg;

	localparam int DIR_BITS = 16;
	localparam int DIR_FRAC = 15;

	typedef struct packed {
		logic full;
		logic empty;
	} cot_fifo_status_t;

endpackage

// File: hw/rtl/cot_front.sv
// ----------------------------------------------------------------------------
// cot_front
// Front pipeline: differences, squares, hit classification.
// ----------------------------------------------------------------------------
module cot_front import cot_pkg::*; #(
	parameter int CB = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic signed [CB-1:0] first_x,
	input  logic signed [CB-1:0] first_y,
	input  logic [CB-2:0]       first_radius,
	input  logic signed [CB-1:0] second_x,
	input  logic signed [CB-1:0] second_y,
	input  logic [CB-2:0]       second_radius,
	input  logic                q_full,
	output logic                push,
	output logic                hit,
	output logic [CB-1:0]       sum,
	output logic [2*CB-1:0]     rad,
	output logic [CB-1:0]       ax,
	output logic [CB-1:0]       ay,
	output logic                nx,
	output logic                ny
);

	logic            fen;
	logic            v_s1, v_s2, v_s3;
	logic [CB-1:0]   ax_s1, ay_s1, s_s1;
	logic            nx_s1, ny_s1;
	logic [2*CB-1:0] x2_s2, y2_s2, ss_s2;
	logic [CB-1:0]   ax_s2, ay_s2, s_s2;
	logic            nx_s2, ny_s2;
	logic [CB-1:0]   ax_s3, ay_s3, s_s3;
	logic [2*CB-1:0] rad_s3;
	logic            hit_s3, nx_s3, ny_s3;
	logic signed [CB:0] dx, dy;
	logic [2*CB:0]   d2;
	logic            hit_c;

	assign fen      = !v_s3 || !q_full;
	assign in_stall = !fen;
	assign push     = v_s3 && !q_full;

	assign dx = {first_x[CB-1], first_x} - {second_x[CB-1], second_x};
	assign dy = {first_y[CB-1], first_y} - {second_y[CB-1], second_y};

	assign d2    = {1'b0, x2_s2} + {1'b0, y2_s2};
	assign hit_c = d2 < {1'b0, ss_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (fen) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (fen) begin
			ax_s1  <= dx[CB] ? CB'(-dx) : dx[CB-1:0];
			ay_s1  <= dy[CB] ? CB'(-dy) : dy[CB-1:0];
			nx_s1  <= dx[CB];
			ny_s1  <= dy[CB];
			s_s1   <= {1'b0, first_radius} + {1'b0, second_radius};
			x2_s2  <= ax_s1 * ax_s1;
			y2_s2  <= ay_s1 * ay_s1;
			ss_s2  <= s_s1 * s_s1;
			ax_s2  <= ax_s1;
			ay_s2  <= ay_s1;
			s_s2   <= s_s1;
			nx_s2  <= nx_s1;
			ny_s2  <= ny_s1;
			hit_s3 <= hit_c;
			rad_s3 <= hit_c ? ss_s2 - d2[2*CB-1:0] : '0;
			ax_s3  <= hit_c ? ax_s2 : '0;
			ay_s3  <= hit_c ? ay_s2 : '0;
			s_s3   <= hit_c ? s_s2 : '0;
			nx_s3  <= hit_c && nx_s2;
			ny_s3  <= hit_c && ny_s2;
		end
	end

	assign hit = hit_s3;
	assign sum = s_s3;
	assign rad = rad_s3;
	assign ax  = ax_s3;
	assign ay  = ay_s3;
	assign nx  = nx_s3;
	assign ny  = ny_s3;

endmodule

// File: hw/rtl/cot_fifo.sv
// ----------------------------------------------------------------------------
// cot_fifo
// Two-entry queue between front and back.
// ----------------------------------------------------------------------------
module cot_fifo import cot_pkg::*; #(
	parameter int W = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [W-1:0]     wdata,
	input  logic             pop,
	output logic [W-1:0]     rdata,
	output cot_fifo_status_t status
);

	logic [W-1:0] mem_q [2];
	logic         wptr_q, rptr_q;
	logic [1:0]   cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) wptr_q <= !wptr_q;
			if (pop)  rptr_q <= !rptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wptr_q] <= wdata;
	end

	assign rdata        = mem_q[rptr_q];
	assign status.full  = cnt_q[1];
	assign status.empty = cnt_q == 2'd0;

endmodule

// File: hw/rtl/cot_back.sv
// ----------------------------------------------------------------------------
// cot_back
// Back pipeline: digit-per-stage square root and two Q1.15 dividers.
// ----------------------------------------------------------------------------
module cot_back import cot_pkg::*; #(
	parameter int CB = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    in_v,
	input  logic                    hit_i,
	input  logic [CB-1:0]           sum_i,
	input  logic [2*CB-1:0]         rad_i,
	input  logic [CB-1:0]           ax_i,
	input  logic [CB-1:0]           ay_i,
	input  logic                    nx_i,
	input  logic                    ny_i,
	output logic                    out_v,
	output logic                    hit_o,
	output logic [CB-1:0]           sum_o,
	output logic [CB-1:0]           root_o,
	output logic signed [DIR_BITS-1:0] dirx_o,
	output logic signed [DIR_BITS-1:0] diry_o
);

	localparam int L = (CB > DIR_FRAC) ? CB : DIR_FRAC;

	logic              v_s    [L+1];
	logic              hit_s  [L+1];
	logic              nx_s   [L+1];
	logic              ny_s   [L+1];
	logic [CB-1:0]     s_s    [L+1];
	logic [2*CB-1:0]   rad_s  [L+1];
	logic [CB:0]       srem_s [L+1];
	logic [CB-1:0]     root_s [L+1];
	logic [CB-1:0]     rx_s   [L+1];
	logic [CB-1:0]     ry_s   [L+1];
	logic [DIR_FRAC-1:0] qx_s [L+1];
	logic [DIR_FRAC-1:0] qy_s [L+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_s[0]  <= hit_i;
			nx_s[0]   <= nx_i;
			ny_s[0]   <= ny_i;
			s_s[0]    <= sum_i;
			rad_s[0]  <= rad_i;
			srem_s[0] <= '0;
			root_s[0] <= '0;
			rx_s[0]   <= ax_i;
			ry_s[0]   <= ay_i;
			qx_s[0]   <= '0;
			qy_s[0]   <= '0;
		end
	end

	for (genvar k = 0; k < L; k++) begin : g_stage
		logic [CB:0]         srem_n;
		logic [CB-1:0]       root_n;
		logic [CB-1:0]       rx_n, ry_n;
		logic [DIR_FRAC-1:0] qx_n, qy_n;

		if (k < CB) begin : g_sqrt
			logic [CB+2:0] cat, trial;
			always_comb begin
				cat   = {srem_s[k], rad_s[k][2*(CB-1-k)+1 -: 2]};
				trial = {1'b0, root_s[k], 2'b01};
				if (cat >= trial) begin
					srem_n = (CB+1)'(cat - trial);
					root_n = {root_s[k][CB-2:0], 1'b1};
				end else begin
					srem_n = cat[CB:0];
					root_n = {root_s[k][CB-2:0], 1'b0};
				end
			end
		end else begin : g_sqrt_idle
			assign srem_n = srem_s[k];
			assign root_n = root_s[k];
		end

		if (k < DIR_FRAC) begin : g_div
			logic [CB:0] shx, shy;
			always_comb begin
				shx = {rx_s[k], 1'b0};
				shy = {ry_s[k], 1'b0};
				if (shx >= {1'b0, s_s[k]}) begin
					rx_n = CB'(shx - {1'b0, s_s[k]});
					qx_n = {qx_s[k][DIR_FRAC-2:0], 1'b1};
				end else begin
					rx_n = shx[CB-1:0];
					qx_n = {qx_s[k][DIR_FRAC-2:0], 1'b0};
				end
				if (shy >= {1'b0, s_s[k]}) begin
					ry_n = CB'(shy - {1'b0, s_s[k]});
					qy_n = {qy_s[k][DIR_FRAC-2:0], 1'b1};
				end else begin
					ry_n = shy[CB-1:0];
					qy_n = {qy_s[k][DIR_FRAC-2:0], 1'b0};
				end
			end
		end else begin : g_div_idle
			assign rx_n = rx_s[k];
			assign ry_n = ry_s[k];
			assign qx_n = qx_s[k];
			assign qy_n = qy_s[k];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				hit_s[k+1]  <= hit_s[k];
				nx_s[k+1]   <= nx_s[k];
				ny_s[k+1]   <= ny_s[k];
				s_s[k+1]    <= s_s[k];
				rad_s[k+1]  <= rad_s[k];
				srem_s[k+1] <= srem_n;
				root_s[k+1] <= root_n;
				rx_s[k+1]   <= rx_n;
				ry_s[k+1]   <= ry_n;
				qx_s[k+1]   <= qx_n;
				qy_s[k+1]   <= qy_n;
			end
		end
	end

	logic [DIR_BITS-1:0] qxe, qye;
	assign qxe = {1'b0, qx_s[L]};
	assign qye = {1'b0, qy_s[L]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v <= 1'b0;
		end else if (en) begin
			out_v <= v_s[L];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_o  <= hit_s[L];
			sum_o  <= hit_s[L] ? s_s[L] : '0;
			root_o <= hit_s[L] ? root_s[L] : '0;
			dirx_o <= !hit_s[L] ? '0 : (nx_s[L] ? -qxe : qxe);
			diry_o <= !hit_s[L] ? '0 : (ny_s[L] ? -qye : qye);
		end
	end

endmodule

// File: hw/rtl/circle_overlap_test_top.sv
// Circle overlap test: hit, overlap, impact depth and unit direction per circle pair.
// The square root in the back pipeline resolves one digit per stage.
// Throughput: one circle pair per cycle while out_stall is low;
//   the front and back stall independently.
// Reset: arst_n clears all valid flags and the queue; no result is pending after it.
`include "circle_overlap_test_top_assert.svh"
// ----------------------------------------------------------------------------
// circle_overlap_test_top
// Front classifier, two-entry queue and arithmetic back pipeline.
// ----------------------------------------------------------------------------
module circle_overlap_test_top import cot_pkg::*; #(
	parameter int COORD_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [COORD_BITS-1:0]  first_x,
	input  logic signed [COORD_BITS-1:0]  first_y,
	input  logic [COORD_BITS-2:0]         first_radius,
	input  logic signed [COORD_BITS-1:0]  second_x,
	input  logic signed [COORD_BITS-1:0]  second_y,
	input  logic [COORD_BITS-2:0]         second_radius,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          hit,
	output logic [COORD_BITS-1:0]         overlap_distance,
	output logic [COORD_BITS-1:0]         impact_depth,
	output logic signed [DIR_BITS-1:0]    direction_x,
	output logic signed [DIR_BITS-1:0]    direction_y
);

	localparam int CB = COORD_BITS;
	localparam int W  = 5 * CB + 3;

	cot_fifo_status_t fst;
	logic             push, pop, en;
	logic             f_hit, f_nx, f_ny;
	logic [CB-1:0]    f_sum, f_ax, f_ay;
	logic [2*CB-1:0]  f_rad;
	logic [W-1:0]     wdata, rdata;

	cot_front #(.CB(CB)) u_front (
		.clk, .arst_n, .in_valid, .in_stall,
		.first_x, .first_y, .first_radius,
		.second_x, .second_y, .second_radius,
		.q_full (fst.full),
		.push,
		.hit (f_hit), .sum (f_sum), .rad (f_rad),
		.ax (f_ax), .ay (f_ay), .nx (f_nx), .ny (f_ny)
	);

	assign wdata = {f_hit, f_sum, f_rad, f_ax, f_ay, f_nx, f_ny};
	assign en    = !out_valid || !out_stall;
	assign pop   = en && !fst.empty;

	cot_fifo #(.W(W)) u_fifo (
		.clk, .arst_n, .push, .wdata, .pop, .rdata, .status (fst)
	);

	cot_back #(.CB(CB)) u_back (
		.clk, .arst_n, .en,
		.in_v   (!fst.empty),
		.hit_i  (rdata[W-1]),
		.sum_i  (rdata[W-2 -: CB]),
		.rad_i  (rdata[W-2-CB -: 2*CB]),
		.ax_i   (rdata[2*CB+1 -: CB]),
		.ay_i   (rdata[CB+1 -: CB]),
		.nx_i   (rdata[1]),
		.ny_i   (rdata[0]),
		.out_v  (out_valid),
		.hit_o  (hit),
		.sum_o  (overlap_distance),
		.root_o (impact_depth),
		.dirx_o (direction_x),
		.diry_o (direction_y)
	);

	`COT_ASSERT(a_miss_zero, out_valid && !hit |-> overlap_distance == '0 && impact_depth == '0 && direction_x == '0 && direction_y == '0, "miss with nonzero fields")
	`COT_ASSERT(a_hit_sum, out_valid && hit |-> overlap_distance != '0, "hit with zero radius sum")
	`COT_ASSERT(a_no_overflow, fst.full |-> !push, "queue overflow")
	`COT_ASSERT_ALWAYS(a_reset_idle, !arst_n |=> !out_valid && fst.empty, "not idle in reset")

endmodule

// File: tb/circle_overlap_test_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circle_overlap_test_top_tb
// Self-checking bench for the circle overlap test: a directed table of circle
// pairs, then random pairs biased toward hits and near-touching cases, each
// result checked in order against an in-bench collision predictor.
// ----------------------------------------------------------------------------
module circle_overlap_test_top_tb;
	import cot_pkg::*;

	localparam int CB = 16;
	localparam int LAT = CB + 6;
	localparam int WDOG_LIMIT = 4000;
	localparam int N_RANDOM = 1700;

	typedef struct packed {
		logic signed [CB-1:0] ax;
		logic signed [CB-1:0] ay;
		logic [CB-2:0]        ar;
		logic signed [CB-1:0] bx;
		logic signed [CB-1:0] by;
		logic [CB-2:0]        br;
	} pair_t;

	localparam int PAIR_BITS = $bits(pair_t);

	typedef struct packed {
		logic                       hit;
		logic [CB-1:0]              span;
		logic [CB-1:0]              depth;
		logic signed [DIR_BITS-1:0] dir_x;
		logic signed [DIR_BITS-1:0] dir_y;
	} contact_t;

	typedef struct packed {
		pair_t    p;
		logic     known;
		contact_t c;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [CB-1:0] first_x = '0, first_y = '0, second_x = '0, second_y = '0;
	logic [CB-2:0] first_radius = '0, second_radius = '0;
	logic out_valid;
	logic out_stall = 1'b1;
	logic hit;
	logic [CB-1:0] overlap_distance, impact_depth;
	logic signed [DIR_BITS-1:0] direction_x, direction_y;

	contact_t contact_q[$];
	int errors = 0;
	int wdog = 0;
	bit quiet = 0;
	bit rx_idle_on = 1;

	always #2 clk = ~clk;

	circle_overlap_test_top #(.COORD_BITS(CB)) dut (.*);

	function automatic longint unsigned root_floor(longint unsigned v);
		longint unsigned res, bit_v;
		res = 0;
		bit_v = 64'd1 << 62;
		while (bit_v > v) bit_v >>= 2;
		while (bit_v != 0) begin
			if (v >= res + bit_v) begin
				v -= res + bit_v;
				res = (res >> 1) + bit_v;
			end else begin
				res >>= 1;
			end
			bit_v >>= 2;
		end
		return res;
	endfunction

	function automatic logic [15:0] unit_q15(longint d, longint unsigned s);
		longint unsigned m, q;
		m = (d < 0) ? -d : d;
		q = (m << 15) / s;
		if (d < 0) q = -q;
		return q[15:0];
	endfunction

	function automatic contact_t collide(pair_t p);
		contact_t c;
		longint dx, dy;
		longint unsigned s, mx, my, d2, s2;
		c = '0;
		dx = longint'(p.ax) - longint'(p.bx);
		dy = longint'(p.ay) - longint'(p.by);
		s = longint'(p.ar) + longint'(p.br);
		mx = (dx < 0) ? -dx : dx;
		my = (dy < 0) ? -dy : dy;
		if (mx < s && my < s) begin
			d2 = mx * mx + my * my;
			s2 = s * s;
			if (d2 < s2) begin
				c.hit = 1'b1;
				c.span = s[CB-1:0];
				c.depth = CB'(root_floor(s2 - d2));
				c.dir_x = unit_q15(dx, s);
				c.dir_y = unit_q15(dy, s);
			end
		end
		return c;
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %0h want %0h", what, got, want);
		errors++;
	endtask

	// receive side
	always @(posedge clk) begin
		contact_t w;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (contact_q.size() == 0) begin
					report("unexpected transfer", '0, '0);
				end else begin
					w = contact_q.pop_front();
					if (hit !== w.hit) report("hit", 32'(hit), 32'(w.hit));
					if (overlap_distance !== w.span)
						report("overlap_distance", 32'(overlap_distance), 32'(w.span));
					if (impact_depth !== w.depth)
						report("impact_depth", 32'(impact_depth), 32'(w.depth));
					if (direction_x !== w.dir_x)
						report("direction_x", 32'(direction_x), 32'(w.dir_x));
					if (direction_y !== w.dir_y)
						report("direction_y", 32'(direction_y), 32'(w.dir_y));
				end
			end
		end
	end

	// stall bursts
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			n = $urandom_range(1, 30);
			repeat (n) @(posedge clk) out_stall <= 1'b0;
			if (!quiet && rx_idle_on) begin
				n = $urandom_range(1, 18);
				repeat (n) @(posedge clk) out_stall <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) wdog <= 0;
		else wdog <= wdog + 1;
		if (wdog >= WDOG_LIMIT) begin
			$display("watchdog expired");
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic send(pair_t p, contact_t want, bit known);
		contact_t pred;
		first_x <= p.ax; first_y <= p.ay; first_radius <= p.ar;
		second_x <= p.bx; second_y <= p.by; second_radius <= p.br;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pred = collide(p);
		if (known && pred !== want) report("table row", 32'(pred), 32'(want));
		contact_q.push_back(pred);
	endtask

	task automatic gap;
		int n;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			n = $urandom_range(1, 18);
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	function automatic pair_t rand_pair();
		pair_t p;
		int k;
		p = PAIR_BITS'({$urandom, $urandom, $urandom});
		k = $urandom_range(0, 9);
		if (k < 6) begin
			// near pair: offsets of at most 800 per axis, or in x exactly the radius sum
			p.ar = 15'($urandom_range(0, (k < 3) ? 400 : 32767));
			p.br = 15'($urandom_range(0, (k < 3) ? 400 : 32767));
			p.bx = p.ax + $signed(16'($urandom_range(0, 1600)) - 16'sd800);
			p.by = p.ay + $signed(16'($urandom_range(0, 1600)) - 16'sd800);
			if (k == 5) begin
				p.bx = p.ax - 16'({1'b0, p.ar} + {1'b0, p.br});
				p.by = p.ay;
			end
		end
		return p;
	endfunction

	row_t dir_rows[$];

	initial begin
		pair_t p;
		dir_rows = '{
			'{'{16'sd0, 16'sd0, 15'd0, 16'sd0, 16'sd0, 15'd0}, 1'b1, '0},
			'{'{16'sd0, 16'sd0, 15'd16, 16'sd0, 16'sd0, 15'd0},
				1'b1, '{1'b1, 16'd16, 16'd16, 16'sd0, 16'sd0}},
			'{'{16'sd10, 16'sd0, 15'd5, 16'sd0, 16'sd0, 15'd5}, 1'b1, '0},
			'{'{16'sd3, 16'sd4, 15'd3, 16'sd0, 16'sd0, 15'd3}, 1'b1,
				'{1'b1, 16'd6, 16'd3, 16'sd16384, 16'sd21845}},
			'{'{16'sd0, 16'sd0, 15'd32767, 16'sd0, 16'sd0, 15'd32767},
				1'b1, '{1'b1, 16'd65534, 16'd65534, 16'sd0, 16'sd0}},
			'{'{16'sh7fff, 16'sh7fff, 15'd32767, -16'sh8000, -16'sh8000, 15'd32767},
				1'b1, '0},
			'{'{-16'sh8000, 16'sh7fff, 15'd32767, 16'sh7fff, -16'sh8000, 15'd32767},
				1'b1, '0},
			'{'{16'sh7fff, 16'sh7fff, 15'd1, 16'sh7fff, 16'sh7fff, 15'd0},
				1'b1, '{1'b1, 16'd1, 16'd1, 16'sd0, 16'sd0}},
			'{'{16'sd100, 16'sd0, 15'd32767, 16'sd0, 16'sd0, 15'd32767}, 1'b0, '0},
			'{'{-16'sd30000, 16'sd20000, 15'd20000, 16'sd30000, -16'sd20000, 15'd32767},
				1'b0, '0},
			'{'{-16'sd1, -16'sd1, 15'd2, 16'sd0, 16'sd0, 15'd0}, 1'b0, '0},
			'{'{16'sh5555, 16'shaaa, 15'h2aaa, 16'sh5550, 16'sh0aa0, 15'h5555}, 1'b0, '0}
		};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_rows[i]) send(dir_rows[i].p, dir_rows[i].c, dir_rows[i].known);
		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == N_RANDOM / 2) begin
				in_valid <= 1'b0;
				while (contact_q.size() != 0) @(posedge clk);
			end
			if (i == N_RANDOM - 200) quiet = 1;
			gap();
			p = rand_pair();
			send(p, '0, 1'b0);
		end
		in_valid <= 1'b0;
		while (contact_q.size() != 0) @(posedge clk);
		repeat (LAT) @(posedge clk);
		if (errors == 0) $display("Simulation PASSED");
		else $display("Simulation FAILED");
		$finish;
	end

endmodule
